// ===== hw/rtl/spjb_pkg.sv =====
package spjb_pkg;

	// Store geometry and audio clock
	localparam int unsigned STORE_FRAMES = 32768;
	localparam int unsigned SAMPLE_RATE  = 44100;
	localparam int unsigned PTR_W        = $clog2(STORE_FRAMES);
	localparam int unsigned CNT_W        = $clog2(STORE_FRAMES + 1);
	localparam int unsigned LIM_W        = (CNT_W > 16) ? CNT_W : 16;
	localparam int unsigned MAXQ_RESET   = SAMPLE_RATE / 2;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Item kinds
	typedef enum logic [1:0] {
		FUNC_PUSH  = 2'd0,
		FUNC_PULL  = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	// Register indexes
	typedef enum logic [1:0] {
		CFG_ENABLED = 2'd0,
		CFG_DEPTH   = 2'd1,
		CFG_MAXQ    = 2'd2,
		CFG_NONE    = 2'd3
	} cfg_idx_t;

	// Allowed priming depths in ms
	localparam int unsigned DEPTH_STEPS [7] = '{0, 4, 8, 16, 32, 64, 128};

	// Priming targets in frames, ceil(rate * ms / 1000) per step
	localparam int unsigned TARGET_TAB [7] = '{
		0,
		(SAMPLE_RATE * 4 + 999) / 1000,
		(SAMPLE_RATE * 8 + 999) / 1000,
		(SAMPLE_RATE * 16 + 999) / 1000,
		(SAMPLE_RATE * 32 + 999) / 1000,
		(SAMPLE_RATE * 64 + 999) / 1000,
		(SAMPLE_RATE * 128 + 999) / 1000
	};

	// Nearest depth step, ties go to the lower step
	function automatic logic [2:0] quantize_depth(input logic [9:0] ms);
		logic [2:0]  best;
		logic [10:0] best_dist;
		logic [10:0] d;
		logic [10:0] s;
		best      = 3'd0;
		best_dist = {1'b0, ms};
		for (int i = 1; i < 7; i++) begin
			s = 11'(DEPTH_STEPS[i]);
			d = ({1'b0, ms} > s) ? ({1'b0, ms} - s) : (s - {1'b0, ms});
			if (d < best_dist) begin
				best      = 3'(i);
				best_dist = d;
			end
		end
		return best;
	endfunction

	// Advance a pointer by n frames modulo the store size, n up to store size + 1
	function automatic ptr_t ptr_add(input ptr_t p, input cnt_t n);
		logic [CNT_W:0] nn;
		logic [CNT_W:0] sum;
		nn = {1'b0, n};
		if (nn >= (CNT_W+1)'(STORE_FRAMES)) begin
			nn = nn - (CNT_W+1)'(STORE_FRAMES);
		end
		sum = (CNT_W+1)'(p) + nn;
		if (sum >= (CNT_W+1)'(STORE_FRAMES)) begin
			sum = sum - (CNT_W+1)'(STORE_FRAMES);
		end
		return sum[PTR_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/spjb_store.sv =====
module spjb_store (
	input  logic               clk,
	input  logic               we,
	input  spjb_pkg::ptr_t     waddr,
	input  logic [31:0]        wdata,
	input  logic               re,
	input  spjb_pkg::ptr_t     raddr,
	output logic [31:0]        rdata
);
	import spjb_pkg::*;

	logic [31:0] mem [STORE_FRAMES];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/stereo_playout_jitter_buffer.sv =====
// A result word reaches m_tvalid through the registered frame store read with the stage 1
// result, then through the output register; either can hold while m_tready is low.
// Throughput: one word per cycle, each reads the store, a push also writes; s_tready drops
// while a cfg word is offered; a result waiting on m_tready lets one more word in.
// Reset (arst_n, asynchronous): pointers, count, priming and registers cleared,
// frame limit to 22050; store contents are undefined and are never played unwritten.
module stereo_playout_jitter_buffer (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] left_in, [31:16] right_in
	input  logic [2:0]  s_tuser,   // [1:0] func, [2] batch_start
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [15:0] left_out, [31:16] right_out, [47:32] queued_frames
	output logic [2:0]  m_tuser,   // [0] audio_valid, [1] underrun, [2] dropped_oldest
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import spjb_pkg::*;

	typedef struct packed {
		logic        audio_valid;
		logic        underrun;
		logic        dropped_oldest;
		logic [15:0] queued_frames;
	} res_t;

	// State
	ptr_t        rp_q, wp_q;
	cnt_t        cnt_q;
	logic        primed_q;
	logic        enabled_q;
	logic [9:0]  depth_q;
	logic [15:0] maxq_q;

	// Stage and output registers
	logic        vld_s1;
	res_t        res_s1;
	logic        out_vld_q;
	res_t        res_q;
	logic [31:0] frame_q;

	// Next-state logic
	ptr_t        rp_n, wp_n;
	cnt_t        cnt_n;
	logic        primed_n;
	res_t        res_n;
	logic        store_we;
	logic [31:0] rdata;
	logic        in_acc;
	logic        s1_adv;

	logic [2:0]     qidx;
	logic [31:0]    target;
	logic [LIM_W-1:0] maxw;
	cnt_t           limit;
	logic           full;
	cnt_t           c2;
	cnt_t           excess;
	logic           prim_try;
	func_t          func;

	assign func   = func_t'(s_tuser[1:0]);
	assign qidx   = quantize_depth(depth_q);
	assign target = 32'(TARGET_TAB[qidx]);
	assign maxw   = LIM_W'(maxq_q);
	assign limit  = (maxw < LIM_W'(STORE_FRAMES)) ? CNT_W'(maxw) : CNT_W'(STORE_FRAMES);
	assign full   = (cnt_q >= CNT_W'(STORE_FRAMES));
	assign c2     = full ? cnt_q : (cnt_q + CNT_W'(1));
	assign excess = (c2 > limit) ? (c2 - limit) : '0;
	assign prim_try = primed_q | (s_tuser[2] & (32'(cnt_q) >= target));

	// Handshakes; hold off input while a configuration word is offered
	assign s1_adv    = vld_s1 & (~out_vld_q | m_tready);
	assign s_tready  = (~vld_s1 | s1_adv) & ~cfg_valid;
	assign in_acc    = s_tvalid & s_tready;
	assign cfg_ready = 1'b1;

	// Decode one word against the queue state
	always_comb begin
		rp_n     = rp_q;
		wp_n     = wp_q;
		cnt_n    = cnt_q;
		primed_n = primed_q;
		store_we = 1'b0;
		res_n    = '0;
		unique case (func)
			FUNC_PUSH: begin
				if (enabled_q) begin
					store_we = 1'b1;
					wp_n     = ptr_add(wp_q, CNT_W'(1));
					rp_n     = ptr_add(rp_q, excess + CNT_W'(full));
					cnt_n    = (c2 > limit) ? limit : c2;
					res_n.dropped_oldest = full | (c2 > limit);
				end
			end
			FUNC_PULL: begin
				if (enabled_q) begin
					primed_n = prim_try;
					if (prim_try && cnt_q != '0) begin
						res_n.audio_valid = 1'b1;
						rp_n  = ptr_add(rp_q, CNT_W'(1));
						cnt_n = cnt_q - CNT_W'(1);
					end else if (prim_try) begin
						res_n.underrun = 1'b1;
						if (target != '0) begin
							primed_n = 1'b0;
						end
					end
				end
			end
			FUNC_CLEAR: begin
				cnt_n = '0;
				rp_n  = wp_q;
			end
			default: begin
			end
		endcase
		res_n.queued_frames = 16'(cnt_n);
	end

	// Frame store, read at the oldest frame on every accepted word
	spjb_store u_store (
		.clk   (clk),
		.we    (in_acc & store_we),
		.waddr (wp_q),
		.wdata (s_tdata),
		.re    (in_acc),
		.raddr (rp_q),
		.rdata (rdata)
	);

	// Queue state and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q      <= '0;
			wp_q      <= '0;
			cnt_q     <= '0;
			primed_q  <= 1'b0;
			enabled_q <= 1'b0;
			depth_q   <= '0;
			maxq_q    <= 16'(MAXQ_RESET);
		end else begin
			if (in_acc) begin
				rp_q     <= rp_n;
				wp_q     <= wp_n;
				cnt_q    <= cnt_n;
				primed_q <= primed_n;
			end else if (cfg_valid) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_ENABLED: begin
						if (!cfg_data[0]) begin
							cnt_q <= '0;
							rp_q  <= wp_q;
						end else if (!enabled_q) begin
							primed_q <= (qidx == 3'd0);
						end
						enabled_q <= cfg_data[0];
					end
					CFG_DEPTH: begin
						depth_q <= cfg_data[9:0];
						if (quantize_depth(cfg_data[9:0]) != qidx) begin
							cnt_q    <= '0;
							rp_q     <= wp_q;
							primed_q <= (quantize_depth(cfg_data[9:0]) == 3'd0);
						end
					end
					CFG_MAXQ: begin
						maxq_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_acc) begin
			vld_s1 <= 1'b1;
		end else if (s1_adv) begin
			vld_s1 <= 1'b0;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_s1 <= res_n;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_adv) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Output register payload, silence unless a frame was played
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_q   <= res_s1;
			frame_q <= res_s1.audio_valid ? rdata : '0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {res_q.queued_frames, frame_q};
	assign m_tuser  = {res_q.dropped_oldest, res_q.underrun, res_q.audio_valid};

endmodule

// ===== dv/tb_stereo_playout_jitter_buffer.sv =====
`timescale 1ns / 100ps

module tb_stereo_playout_jitter_buffer;

	import spjb_pkg::*;

	localparam int QUIET_LIMIT = 500;

	// Expected playout word, packed as the result fields
	typedef struct packed {
		logic [15:0] left;
		logic [15:0] right;
		logic        valid;
		logic        under;
		logic        dropped;
		logic [15:0] queued;
	} playout_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // [15:0] left_in, [31:16] right_in
	logic [2:0]  s_tuser = '0;   // [1:0] func, [2] batch_start
	logic        m_tvalid;
	logic        m_tready = 1'b1;
	logic [47:0] m_tdata;        // [15:0] left_out, [31:16] right_out, [47:32] queued_frames
	logic [2:0]  m_tuser;        // [0] audio_valid, [1] underrun, [2] dropped_oldest
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// Shadow of the buffer and its registers
	logic [31:0] buf_store [STORE_FRAMES];
	int unsigned buf_rd = 0;
	int unsigned buf_wr = 0;
	int unsigned buf_count = 0;
	logic        buf_primed = 1'b0;
	logic        reg_enabled = 1'b0;
	logic [9:0]  reg_depth = '0;
	logic [15:0] reg_maxq = 16'(MAXQ_RESET);

	playout_t    playout_due [$];
	int          mismatches = 0;
	int          quiet_cycles = 0;
	int          rx_hold = 0;
	bit          tx_idle_en = 1'b1;
	bit          rx_idle_en = 1'b1;

	stereo_playout_jitter_buffer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic [15:0] rnd16();
		return 16'($urandom());
	endfunction

	// Nearest priming step in ms; a midpoint goes to the lower step
	function automatic int unsigned depth_step(logic [9:0] ms);
		if (ms <= 2) return 0;
		else if (ms <= 6) return 4;
		else if (ms <= 12) return 8;
		else if (ms <= 24) return 16;
		else if (ms <= 48) return 32;
		else if (ms <= 96) return 64;
		return 128;
	endfunction

	// Frames needed before playout starts, rounded up
	function automatic int unsigned prime_target();
		longint unsigned prod;
		prod = 64'(SAMPLE_RATE) * 64'(depth_step(reg_depth));
		return 32'((prod + 999) / 1000);
	endfunction

	function automatic int unsigned step_ptr(int unsigned p, int unsigned n);
		return (p + n) % STORE_FRAMES;
	endfunction

	function automatic void flush_model();
		buf_count = 0;
		buf_rd    = buf_wr;
	endfunction

	// Apply one register write to the shadow state
	function automatic void apply_reg(cfg_idx_t idx, logic [15:0] d);
		case (idx)
			CFG_ENABLED: begin
				if (!d[0]) flush_model();
				else if (!reg_enabled) buf_primed = (depth_step(reg_depth) == 0);
				reg_enabled = d[0];
			end
			CFG_DEPTH: begin
				if (depth_step(d[9:0]) != depth_step(reg_depth)) begin
					flush_model();
					buf_primed = (depth_step(d[9:0]) == 0);
				end
				reg_depth = d[9:0];
			end
			CFG_MAXQ: reg_maxq = d;
			default: ;
		endcase
	endfunction

	// Advance the shadow buffer by one input word and return its result
	function automatic playout_t compute_playout(func_t f, logic [15:0] l, logic [15:0] r,
		logic b);
		playout_t    res;
		int unsigned lim;
		int unsigned tgt;
		logic [31:0] w;
		res = '0;
		case (f)
			FUNC_PUSH: begin
				if (reg_enabled) begin
					lim = (reg_maxq < STORE_FRAMES) ? reg_maxq : STORE_FRAMES;
					// store full: drop the oldest to make room
					if (buf_count >= STORE_FRAMES) begin
						buf_rd = step_ptr(buf_rd, 1);
						buf_count--;
						res.dropped = 1'b1;
					end
					buf_store[buf_wr] = {r, l};
					buf_wr = step_ptr(buf_wr, 1);
					buf_count++;
					// over the limit: drop every excess oldest frame
					if (buf_count > lim) begin
						buf_rd = step_ptr(buf_rd, buf_count - lim);
						buf_count = lim;
						res.dropped = 1'b1;
					end
				end
			end
			FUNC_PULL: begin
				if (reg_enabled) begin
					tgt = prime_target();
					if (b && !buf_primed && buf_count >= tgt) buf_primed = 1'b1;
					if (buf_primed && buf_count > 0) begin
						w = buf_store[buf_rd];
						res.left  = w[15:0];
						res.right = w[31:16];
						res.valid = 1'b1;
						buf_rd = step_ptr(buf_rd, 1);
						buf_count--;
					end else if (buf_primed) begin
						res.under = 1'b1;
						if (tgt > 0) buf_primed = 1'b0;
					end
				end
			end
			FUNC_CLEAR: flush_model();
			default: ;
		endcase
		res.queued = 16'(buf_count);
		return res;
	endfunction

	task automatic report(string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic cmp_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
	endtask

	// Send one input word after a random gap and queue its expected result
	task automatic send_item(func_t f, logic [15:0] l, logic [15:0] r, logic b);
		int gap;
		gap = tx_idle_en ? $urandom_range(0, 9) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {r, l};
		s_tuser  <= {b, f};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		playout_due = {playout_due, compute_playout(f, l, r, b)};
	endtask

	// Push n random frames, with an occasional ignored word mixed in
	task automatic push_frames(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0) send_item(FUNC_NONE, rnd16(), rnd16(), 1'($urandom()));
			send_item(FUNC_PUSH, rnd16(), rnd16(), 1'($urandom()));
		end
	endtask

	// Hold the input until every expected result has come back
	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (playout_due.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_reg(idx, d);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Disabled after reset: pushes ignored, pulls silent
	task automatic test_idle_after_reset();
		send_item(FUNC_PUSH, 16'h7FFF, 16'h8000, 1'b0);
		send_item(FUNC_PULL, 16'h0000, 16'h0000, 1'b1);
		send_item(FUNC_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1);
		send_item(FUNC_NONE, 16'h8000, 16'h7FFF, 1'b0);
		wait_quiet();
		write_reg(CFG_NONE, rnd16());
	endtask

	task automatic test_edge_cases();
		wait_quiet();
		// bit 0 set, upper bits ignored; zero depth primes at once
		write_reg(CFG_ENABLED, 16'hFFFF);
		send_item(FUNC_PUSH, 16'h7FFF, 16'h8000, 1'b0);
		send_item(FUNC_PUSH, 16'h8000, 16'h7FFF, 1'b1);
		send_item(FUNC_PUSH, 16'h0000, 16'hFFFF, 1'b0);
		send_item(FUNC_PULL, 16'hFFFF, 16'hFFFF, 1'b1);
		send_item(FUNC_PULL, 16'h0000, 16'h0000, 1'b0);
		send_item(FUNC_PULL, 16'h0000, 16'h0000, 1'b0);
		// empty with zero target: underrun but priming kept
		send_item(FUNC_PULL, 16'h0000, 16'h0000, 1'b1);
		send_item(FUNC_PULL, 16'h0000, 16'h0000, 1'b0);
		wait_quiet();
		write_reg(CFG_MAXQ, 16'd1);
		send_item(FUNC_PUSH, 16'h1234, 16'h5678, 1'b0);
		send_item(FUNC_PUSH, 16'h9ABC, 16'hDEF0, 1'b0);
		send_item(FUNC_PULL, 16'h0000, 16'h0000, 1'b0);
		// zero limit drops every pushed frame
		wait_quiet();
		write_reg(CFG_MAXQ, 16'd0);
		send_item(FUNC_PUSH, 16'hFFFF, 16'hFFFF, 1'b0);
		send_item(FUNC_PULL, 16'h0000, 16'h0000, 1'b1);
		wait_quiet();
		write_reg(CFG_MAXQ, 16'd2);
		send_item(FUNC_PUSH, 16'h0001, 16'h0002, 1'b0);
		send_item(FUNC_NONE, 16'hFFFF, 16'hFFFF, 1'b1);
		send_item(FUNC_CLEAR, 16'h0000, 16'h0000, 1'b0);
		send_item(FUNC_PULL, 16'h0000, 16'h0000, 1'b0);
		// depth beyond the top step: deepest priming, never reached here
		wait_quiet();
		write_reg(CFG_DEPTH, 16'd1000);
		send_item(FUNC_PUSH, 16'h4321, 16'h8765, 1'b0);
		send_item(FUNC_PULL, 16'h0000, 16'h0000, 1'b1);
		// disabling empties; pulls silent and pushes ignored
		wait_quiet();
		write_reg(CFG_ENABLED, 16'hFFFE);
		send_item(FUNC_PUSH, 16'h1111, 16'h2222, 1'b0);
		send_item(FUNC_PULL, 16'h0000, 16'h0000, 1'b1);
		send_item(FUNC_CLEAR, 16'h0000, 16'h0000, 1'b0);
	endtask

	// Fill back to back with no idles, drain part of it, then lower the limit
	task automatic test_back_to_back();
		wait_quiet();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		write_reg(CFG_DEPTH, 16'd0);
		write_reg(CFG_MAXQ, 16'hFFFF);
		write_reg(CFG_ENABLED, 16'h0001);
		push_frames(80);
		repeat (20) send_item(FUNC_PULL, rnd16(), rnd16(), 1'($urandom()));
		wait_quiet();
		write_reg(CFG_MAXQ, 16'd5);
		send_item(FUNC_PUSH, rnd16(), rnd16(), 1'b0);
		repeat (7) send_item(FUNC_PULL, rnd16(), rnd16(), 1'($urandom()));
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	// Fill to the priming target, start a batch, then lose priming on underrun
	task automatic test_priming();
		int pre;
		int pulls;
		wait_quiet();
		write_reg(CFG_MAXQ, 16'(250 + $urandom_range(0, 200)));
		write_reg(CFG_DEPTH, {6'($urandom()), 10'($urandom_range(3, 6))});
		write_reg(CFG_ENABLED, 16'h0000);
		write_reg(CFG_ENABLED, 16'h0001);
		pre = $urandom_range(120, 170);
		push_frames(pre);
		send_item(FUNC_PULL, rnd16(), rnd16(), 1'b1);
		push_frames(190 - pre + $urandom_range(0, 20));
		send_item(FUNC_PULL, rnd16(), rnd16(), 1'b0);
		send_item(FUNC_PULL, rnd16(), rnd16(), 1'b1);
		pulls = $urandom_range(10, 20);
		repeat (pulls) send_item(FUNC_PULL, rnd16(), rnd16(), 1'($urandom()));
		// same quantized depth keeps queue and priming
		wait_quiet();
		write_reg(CFG_DEPTH, 16'($urandom_range(3, 6)));
		repeat (3) send_item(FUNC_PULL, rnd16(), rnd16(), 1'($urandom()));
		send_item(FUNC_CLEAR, rnd16(), rnd16(), 1'($urandom()));
		send_item(FUNC_PULL, rnd16(), rnd16(), 1'b0);
		send_item(FUNC_PULL, rnd16(), rnd16(), 1'b1);
	endtask

	// Random settings per phase; mostly push bursts drained by a pull batch
	task automatic test_random_mix();
		int          quota;
		int          sent;
		int          k;
		int          extra;
		int          r;
		logic [15:0] d;
		for (int phase = 0; phase < 6; phase++) begin
			wait_quiet();
			tx_idle_en = ($urandom_range(0, 3) != 0);
			rx_idle_en = ($urandom_range(0, 3) != 0);
			r = $urandom_range(0, 99);
			if (r < 70) d = 16'($urandom_range(0, 2));
			else if (r < 85) d = 16'($urandom_range(3, 6));
			else d = rnd16();
			write_reg(CFG_DEPTH, d);
			r = $urandom_range(0, 99);
			if (r < 50) d = 16'($urandom_range(1, 48));
			else if (r < 65) d = 16'd0;
			else if (r < 80) d = rnd16();
			else d = 16'($urandom_range(200, 600));
			write_reg(CFG_MAXQ, d);
			write_reg(CFG_ENABLED, {15'($urandom()), 1'($urandom_range(0, 99) < 85)});
			quota = $urandom_range(25, 45);
			sent  = 0;
			while (sent < quota) begin
				if ($urandom_range(0, 99) < 85) begin
					k     = $urandom_range(1, 12);
					extra = $urandom_range(0, 2);
					push_frames(k);
					send_item(FUNC_PULL, rnd16(), rnd16(), 1'b1);
					repeat (k + extra - 1) send_item(FUNC_PULL, rnd16(), rnd16(), 1'($urandom()));
					sent += 2 * k + extra;
				end else begin
					send_item(func_t'($urandom_range(0, 3)), rnd16(), rnd16(), 1'($urandom()));
					sent++;
				end
			end
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	// Take result words with random stalls and check each against the oldest expectation
	always @(posedge clk) begin : rx_side
		playout_t e;
		int       n;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (playout_due.size() == 0) begin
					report("result word with nothing pending");
				end else begin
					e = playout_due[0];
					playout_due.delete(0);
					cmp_field("left_out", m_tdata[15:0], e.left);
					cmp_field("right_out", m_tdata[31:16], e.right);
					cmp_field("queued_frames", m_tdata[47:32], e.queued);
					cmp_field("audio_valid", 16'(m_tuser[0]), 16'(e.valid));
					cmp_field("underrun", 16'(m_tuser[1]), 16'(e.under));
					cmp_field("dropped_oldest", 16'(m_tuser[2]), 16'(e.dropped));
				end
				n = rx_idle_en ? $urandom_range(0, 9) : 0;
				if (n != 0) begin
					m_tready <= 1'b0;
					rx_hold = n;
				end
			end else if (!m_tready) begin
				if (rx_hold > 0) rx_hold--;
				if (rx_hold == 0) m_tready <= 1'b1;
			end
		end
	end

	// End the run when no word moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout after %0d cycles with no word accepted", quiet_cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_after_reset();
		test_edge_cases();
		test_back_to_back();
		test_priming();
		test_random_mix();
		wait_quiet();
		if (playout_due.size() != 0) report("expected results left over");
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/spjb_pkg.sv
hw/rtl/spjb_store.sv
hw/rtl/stereo_playout_jitter_buffer.sv
dv/tb_stereo_playout_jitter_buffer.sv
